>>> rtl/rgbds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RGB 2x2 downsampler.
// No dependencies; used by every module of the block.
package rgbds_pkg;

  // Fixed field widths
  localparam int CHAN_W = 8;
  localparam int SIDE_W = 11;
  localparam int MODE_W = 2;
  localparam int DATA_W = 11;

  // Configuration register indexes
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_SIDE_LENGTH = 1'd0;
  localparam logic [IDX_W-1:0] REG_REDUCE_MODE = 1'd1;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd1024;

  // Reduce mode codes; the unused code falls back to maximum
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AVG = 2'd2;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QAW = 2;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  // One 2x2 block ready for reduction
  typedef struct packed {
    pixel_t tl;
    pixel_t tr;
    pixel_t bl;
    pixel_t br;
    logic   frame_end;
  } job_t;

  // Queue fill status seen by the front
  typedef struct packed {
    logic full;
    logic almost_full;
  } qstat_t;

  // Two-input reduction of one channel
  function automatic logic [CHAN_W-1:0] pick(input logic [MODE_W-1:0] mode,
                                              input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] sum;
    logic [CHAN_W-1:0] res;
    sum = {1'b0, a} + {1'b0, b};
    case (mode)
      MODE_MIN: res = (a < b) ? a : b;
      MODE_AVG: res = sum[CHAN_W:1];
      default:  res = (a > b) ? a : b;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/rgbds_front.sv
`timescale 1ns / 1ps
// Front end: raster position tracking, pair line store and job assembly.
// Depends on rgbds_pkg.
module rgbds_front #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rgbds_pkg::SIDE_W-1:0] side_length,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rgbds_pkg::CHAN_W-1:0] red_in,
  input  logic [rgbds_pkg::CHAN_W-1:0] green_in,
  input  logic [rgbds_pkg::CHAN_W-1:0] blue_in,
  input  rgbds_pkg::qstat_t            q_stat,
  output logic                         push,
  output rgbds_pkg::job_t              push_job
);

  localparam int CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int PW    = CW + 1;
  localparam int DEPTH = MAX_SIDE / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = (PW > rgbds_pkg::SIDE_W) ? PW : rgbds_pkg::SIDE_W;
  localparam int PAIR_W = 2 * $bits(rgbds_pkg::pixel_t);

  logic [CW-1:0]        col;
  logic [CW-1:0]        row;
  rgbds_pkg::pixel_t    held;
  logic [PAIR_W-1:0]    line_mem [DEPTH];
  logic [PAIR_W-1:0]    rdata;
  logic                 pend;
  rgbds_pkg::pixel_t    pend_bl;
  rgbds_pkg::pixel_t    pend_br;
  logic                 pend_fe;

  logic                 accept;
  rgbds_pkg::pixel_t    px;
  logic [EW-1:0]        side_ext;
  logic [EW-1:0]        side_cl;
  logic [PW-1:0]        side_p;
  logic [PW-1:0]        lim;
  logic [PW-1:0]        col_p;
  logic [PW-1:0]        row_p;
  logic [PW-1:0]        col_inc;
  logic [PW-1:0]        row_inc;
  logic                 in_blk;
  logic                 wr_en;
  logic                 rd_en;
  logic                 last_blk;
  logic [AW-1:0]        slot;

  // Room check: a pending job lands in the queue on the next edge
  assign in_stall = q_stat.full || (q_stat.almost_full && pend);
  assign accept   = in_valid && !in_stall;
  assign px       = '{blue: blue_in, green: green_in, red: red_in};

  // Clamp the side to the supported range
  always_comb begin
    side_ext = EW'(side_length);
    if (side_ext < EW'(2)) begin
      side_cl = EW'(2);
    end else if (side_ext > EW'(MAX_SIDE)) begin
      side_cl = EW'(MAX_SIDE);
    end else begin
      side_cl = side_ext;
    end
    side_p = PW'(side_cl);
    lim    = side_p & ~PW'(1);
  end

  // Classify the pixel by its place in the 2x2 grid
  always_comb begin
    col_p    = {1'b0, col};
    row_p    = {1'b0, row};
    in_blk   = (col_p < lim) && (row_p < lim);
    wr_en    = accept && in_blk && col[0] && !row[0];
    rd_en    = accept && in_blk && col[0] && row[0];
    last_blk = (col_p == lim - PW'(1)) && (row_p == lim - PW'(1));
    slot     = AW'(col >> 1);
    col_inc  = col_p + PW'(1);
    row_inc  = row_p + PW'(1);
  end

  // Raster position; wraps at the current side
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_inc >= side_p) begin
        col <= '0;
        if (row_inc >= side_p) begin
          row <= '0;
        end else begin
          row <= CW'(row_inc);
        end
      end else begin
        col <= CW'(col_inc);
      end
    end
  end

  // Left pixel of the current pair
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept && in_blk && !col[0]) begin
      held <= px;
    end
  end

  // Pair line store: top-left in the low half, top-right in the high half
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[slot] <= {px, held};
    end
    if (rd_en) begin
      rdata <= line_mem[slot];
    end
  end

  // Bottom pair is registered beside the store read so both reach the queue together
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_bl <= held;
      pend_br <= px;
      pend_fe <= last_blk;
    end
  end

  // Completed block into the queue
  assign push = pend;
  always_comb begin
    push_job.tl        = rdata[PAIR_W/2-1:0];
    push_job.tr        = rdata[PAIR_W-1:PAIR_W/2];
    push_job.bl        = pend_bl;
    push_job.br        = pend_br;
    push_job.frame_end = pend_fe;
  end

  // A pending job must always find room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    pend |-> !q_stat.full)
    else $error("front pushed into a full queue");

endmodule

>>> rtl/rgbds_queue.sv
`timescale 1ns / 1ps
// Short job queue that decouples the front end from the reduction stage.
// Depends on rgbds_pkg.
module rgbds_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rgbds_pkg::job_t   push_job,
  output rgbds_pkg::qstat_t q_stat,
  output logic              q_valid,
  output rgbds_pkg::job_t   q_head,
  input  logic              pop
);

  rgbds_pkg::job_t            slots [rgbds_pkg::QUEUE_DEPTH];
  logic [rgbds_pkg::QAW-1:0]  wr_ptr;
  logic [rgbds_pkg::QAW-1:0]  rd_ptr;
  logic [rgbds_pkg::QAW:0]    count;

  // Status
  assign q_valid            = (count != '0);
  assign q_stat.full        = (count == (rgbds_pkg::QAW+1)'(rgbds_pkg::QUEUE_DEPTH));
  assign q_stat.almost_full = (count == (rgbds_pkg::QAW+1)'(rgbds_pkg::QUEUE_DEPTH - 1));
  assign q_head             = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !q_stat.full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue underflow");

endmodule

>>> rtl/rgbds_back.sv
`timescale 1ns / 1ps
// Back end: per-channel nested reduction of one block into the output register.
// Depends on rgbds_pkg.
module rgbds_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rgbds_pkg::MODE_W-1:0] reduce_mode,
  input  logic                         q_valid,
  input  rgbds_pkg::job_t              q_head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rgbds_pkg::CHAN_W-1:0] red_out,
  output logic [rgbds_pkg::CHAN_W-1:0] green_out,
  output logic [rgbds_pkg::CHAN_W-1:0] blue_out,
  output logic                         frame_end
);

  rgbds_pkg::pixel_t res;

  // f(tl, f(tr, f(bl, br))) on each channel
  always_comb begin
    res.red   = rgbds_pkg::pick(reduce_mode, q_head.tl.red,
                  rgbds_pkg::pick(reduce_mode, q_head.tr.red,
                    rgbds_pkg::pick(reduce_mode, q_head.bl.red, q_head.br.red)));
    res.green = rgbds_pkg::pick(reduce_mode, q_head.tl.green,
                  rgbds_pkg::pick(reduce_mode, q_head.tr.green,
                    rgbds_pkg::pick(reduce_mode, q_head.bl.green, q_head.br.green)));
    res.blue  = rgbds_pkg::pick(reduce_mode, q_head.tl.blue,
                  rgbds_pkg::pick(reduce_mode, q_head.tr.blue,
                    rgbds_pkg::pick(reduce_mode, q_head.bl.blue, q_head.br.blue)));
  end

  // Take a job when the output register is empty or being drained
  assign pop = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      red_out   <= res.red;
      green_out <= res.green;
      blue_out  <= res.blue;
      frame_end <= q_head.frame_end;
    end
  end

endmodule

>>> rtl/rgb_two_by_two_downsampler_core.sv
`timescale 1ns / 1ps
// RGB 2x2 downsampler top level: config registers, front end, job queue, back end.
// A finished block passes the pend register, the job queue and the output register.
// One pixel per clock while not stalled; at most one line store write or read per pixel.
// Reset clears positions, the held pixel, the queue and the output valid;
// side_length returns to 1024 and reduce_mode to maximum. The line store is not cleared.
// Depends on rgbds_pkg, rgbds_front, rgbds_queue, rgbds_back.
module rgb_two_by_two_downsampler_core #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [rgbds_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rgbds_pkg::DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rgbds_pkg::CHAN_W-1:0] red_in,
  input  logic [rgbds_pkg::CHAN_W-1:0] green_in,
  input  logic [rgbds_pkg::CHAN_W-1:0] blue_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rgbds_pkg::CHAN_W-1:0] red_out,
  output logic [rgbds_pkg::CHAN_W-1:0] green_out,
  output logic [rgbds_pkg::CHAN_W-1:0] blue_out,
  output logic                         frame_end
);

  logic [rgbds_pkg::SIDE_W-1:0] side_length;
  logic [rgbds_pkg::MODE_W-1:0] reduce_mode;
  rgbds_pkg::qstat_t            q_stat;
  rgbds_pkg::job_t              push_job;
  rgbds_pkg::job_t              q_head;
  logic                         push;
  logic                         q_valid;
  logic                         pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= rgbds_pkg::SIDE_RESET;
      reduce_mode <= rgbds_pkg::MODE_MAX;
    end else if (cfg_write) begin
      case (cfg_index)
        rgbds_pkg::REG_SIDE_LENGTH: side_length <= cfg_data[rgbds_pkg::SIDE_W-1:0];
        rgbds_pkg::REG_REDUCE_MODE: reduce_mode <= cfg_data[rgbds_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  rgbds_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .side_length (side_length),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .q_stat      (q_stat),
    .push        (push),
    .push_job    (push_job)
  );

  rgbds_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .q_stat   (q_stat),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop)
  );

  rgbds_back u_back (
    .clk         (clk),
    .rst         (rst),
    .reduce_mode (reduce_mode),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .frame_end   (frame_end)
  );

endmodule
